// ----- design/lecf_pkg.sv -----
// ----------------------------------------------------------------------------
// LED color eased crossfade package
// Shared widths, codes and reset constants of the crossfade core.
// ----------------------------------------------------------------------------
package lecf_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned MsW     = 16;
  localparam int unsigned QW      = 17;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 64;

  localparam logic [QW-1:0]   QOne        = 17'h10000;
  localparam logic [MsW-1:0]  MinFadeMs   = 16'd50;
  localparam logic [MsW-1:0]  ResetFadeMs = 16'd2000;
  localparam logic [MsW-1:0]  MsMax       = 16'hFFFF;
  localparam logic [RgbW-1:0] WarmReset   = 24'hFFB46B;
  localparam logic [RgbW-1:0] CoolReset   = 24'hC8C8FF;

  localparam logic [ModeW-1:0] ModeOff    = 2'd0;
  localparam logic [ModeW-1:0] ModeWarm   = 2'd1;
  localparam logic [ModeW-1:0] ModeCold   = 2'd2;
  localparam logic [ModeW-1:0] ModeBreath = 2'd3;

  localparam logic FuncTick    = 1'b0;
  localparam logic FuncRequest = 1'b1;

  localparam logic RegWarm = 1'b0;
  localparam logic RegCool = 1'b1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StDiv   = 5'b00010,
    StSqr   = 5'b00100,
    StBlend = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

endpackage

// ----- design/led_color_eased_crossfade_core.sv -----
// ----------------------------------------------------------------------------
// LED color eased crossfade core
// Mode requests start a color fade; 1 ms ticks advance it with a quadratic
// ease-in-out curve, using a bit-serial divider, squarer and channel blender.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents (lowest bits first)
//  s_axis    in         tuser: func; tdata: mode, duration
//  m_axis    out        tdata: red, green, blue, shown_mode, progress, remaining_ms
//  cfg       in         write enable, register index, 24-bit color
//
//  A request, or a tick after a finished fade, goes from idle straight to emit.
//  An advancing tick runs 16 divide steps, 16 squaring steps and 17 blend
//  steps, one bit per cycle each, plus entry and result load.
//  The tick that reaches the fade length skips divide and squaring.
//  One item is in work at a time; the result register lets the next item in
//  while a result still waits for the downstream side. Reset is asynchronous.
module led_color_eased_crossfade_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lecf_pkg::InDataW-1:0]   s_axis_tdata,  // mode, duration
  input  logic                           s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // red, green, blue, shown_mode, progress, remaining_ms
  output logic [lecf_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [lecf_pkg::RgbW-1:0]      cfg_data_i
);

  lecf_pkg::state_e state_q, state_d;

  logic [lecf_pkg::RgbW-1:0]  warm_q, cool_q;
  logic [lecf_pkg::ModeW-1:0] now_mode_q, now_mode_d, goal_mode_q, goal_mode_d;
  logic [lecf_pkg::RgbW-1:0]  start_rgb_q, start_rgb_d, goal_rgb_q, goal_rgb_d;
  logic [lecf_pkg::RgbW-1:0]  now_rgb_q, now_rgb_d;
  logic [lecf_pkg::QW-1:0]    prog_q, prog_d;
  logic [lecf_pkg::MsW-1:0]   len_q, len_d, elapsed_q, elapsed_d;

  logic [4:0]                 cnt_q, cnt_d;
  logic [lecf_pkg::MsW-1:0]   rem_q, rem_d, quo_q, quo_d, x_q, x_d;
  logic                       hi_q, hi_d;
  logic [31:0]                sq_q, sq_d;
  logic [lecf_pkg::QW-1:0]    e_q, e_d, ne_q, ne_d;
  logic [24:0]                acc_q [3];
  logic [24:0]                acc_d [3];

  logic                       out_valid_q;
  logic [lecf_pkg::OutDataW-1:0] out_data_q;

  logic                       in_xfer, out_free;
  logic [lecf_pkg::ModeW-1:0] in_mode;
  logic [lecf_pkg::MsW-1:0]   in_dur, elapsed_inc, p_w, rem_ms;
  logic [16:0]                r2;
  logic                       ge;
  logic [31:0]                sq_next;
  logic [lecf_pkg::QW-1:0]    sq_shift, e_w;

  assign s_axis_tready = (state_q == lecf_pkg::StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tdata[1:0];
  assign in_dur        = s_axis_tdata[17:2];
  assign elapsed_inc   = (elapsed_q == lecf_pkg::MsMax) ? lecf_pkg::MsMax
                                                        : elapsed_q + 16'd1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign r2       = {rem_q, 1'b0};
  assign ge       = r2 >= {1'b0, len_q};
  assign p_w      = {quo_q[14:0], ge};
  assign sq_next  = {sq_q[30:0], 1'b0} + (quo_q[15] ? {16'b0, x_q} : 32'b0);
  assign sq_shift = sq_next[31:15];
  assign e_w      = hi_q ? lecf_pkg::QOne - sq_shift : sq_shift;

  assign rem_ms = (prog_q[16] || elapsed_q >= len_q) ? '0 : len_q - elapsed_q;

  always_comb begin
    state_d     = state_q;
    now_mode_d  = now_mode_q;
    goal_mode_d = goal_mode_q;
    start_rgb_d = start_rgb_q;
    goal_rgb_d  = goal_rgb_q;
    now_rgb_d   = now_rgb_q;
    prog_d      = prog_q;
    len_d       = len_q;
    elapsed_d   = elapsed_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    x_d         = x_q;
    hi_d        = hi_q;
    sq_d        = sq_q;
    e_d         = e_q;
    ne_d        = ne_q;
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = acc_q[c];
    end

    unique case (state_q)
      lecf_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = lecf_pkg::StEmit;
          if (s_axis_tuser == lecf_pkg::FuncRequest) begin
            if (in_mode != goal_mode_q) begin
              start_rgb_d = now_rgb_q;
              goal_mode_d = in_mode;
              unique case (in_mode)
                lecf_pkg::ModeOff:  goal_rgb_d = '0;
                lecf_pkg::ModeCold: goal_rgb_d = cool_q;
                default:            goal_rgb_d = warm_q;
              endcase
              prog_d    = '0;
              len_d     = (in_dur < lecf_pkg::MinFadeMs) ? lecf_pkg::MinFadeMs : in_dur;
              elapsed_d = '0;
            end
          end else if (prog_q[16]) begin
            now_rgb_d  = goal_rgb_q;
            now_mode_d = goal_mode_q;
          end else begin
            elapsed_d = elapsed_inc;
            for (int c = 0; c < 3; c++) begin
              acc_d[c] = '0;
            end
            if (elapsed_inc >= len_q) begin
              prog_d  = lecf_pkg::QOne;
              e_d     = lecf_pkg::QOne;
              ne_d    = '0;
              cnt_d   = 5'd16;
              state_d = lecf_pkg::StBlend;
            end else begin
              rem_d   = elapsed_inc;
              quo_d   = '0;
              cnt_d   = 5'd15;
              state_d = lecf_pkg::StDiv;
            end
          end
        end
      end

      lecf_pkg::StDiv: begin
        rem_d = ge ? 16'(r2 - {1'b0, len_q}) : r2[15:0];
        quo_d = p_w;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          prog_d  = {1'b0, p_w};
          hi_d    = p_w[15];
          x_d     = p_w[15] ? 16'(lecf_pkg::QOne - {1'b0, p_w}) : p_w;
          quo_d   = x_d;
          sq_d    = '0;
          cnt_d   = 5'd15;
          state_d = lecf_pkg::StSqr;
        end
      end

      lecf_pkg::StSqr: begin
        sq_d  = sq_next;
        quo_d = {quo_q[14:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          e_d     = e_w;
          ne_d    = lecf_pkg::QOne - e_w;
          cnt_d   = 5'd16;
          state_d = lecf_pkg::StBlend;
        end
      end

      lecf_pkg::StBlend: begin
        for (int c = 0; c < 3; c++) begin
          acc_d[c] = {acc_q[c][23:0], 1'b0}
                   + (ne_q[16] ? {17'b0, start_rgb_q[c*8 +: 8]} : 25'b0)
                   + (e_q[16]  ? {17'b0, goal_rgb_q[c*8 +: 8]}  : 25'b0);
        end
        e_d   = {e_q[15:0], 1'b0};
        ne_d  = {ne_q[15:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          for (int c = 0; c < 3; c++) begin
            now_rgb_d[c*8 +: 8] = acc_d[c][23:16];
          end
          state_d = lecf_pkg::StEmit;
        end
      end

      lecf_pkg::StEmit: begin
        if (out_free) begin
          state_d = lecf_pkg::StIdle;
        end
      end

      default: state_d = lecf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lecf_pkg::StIdle;
      warm_q      <= lecf_pkg::WarmReset;
      cool_q      <= lecf_pkg::CoolReset;
      now_mode_q  <= lecf_pkg::ModeOff;
      goal_mode_q <= lecf_pkg::ModeOff;
      start_rgb_q <= '0;
      goal_rgb_q  <= '0;
      now_rgb_q   <= '0;
      prog_q      <= lecf_pkg::QOne;
      len_q       <= lecf_pkg::ResetFadeMs;
      elapsed_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_mode_q  <= now_mode_d;
      goal_mode_q <= goal_mode_d;
      start_rgb_q <= start_rgb_d;
      goal_rgb_q  <= goal_rgb_d;
      now_rgb_q   <= now_rgb_d;
      prog_q      <= prog_d;
      len_q       <= len_d;
      elapsed_q   <= elapsed_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lecf_pkg::RegWarm: warm_q <= cfg_data_i;
          lecf_pkg::RegCool: cool_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == lecf_pkg::StEmit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    x_q   <= x_d;
    hi_q  <= hi_d;
    sq_q  <= sq_d;
    e_q   <= e_d;
    ne_q  <= ne_d;
    for (int c = 0; c < 3; c++) begin
      acc_q[c] <= acc_d[c];
    end
    if (state_q == lecf_pkg::StEmit && out_free) begin
      out_data_q <= {5'b0, rem_ms, prog_q, now_mode_q,
                     now_rgb_q[7:0], now_rgb_q[15:8], now_rgb_q[23:16]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
